FILE: src/sk5_pkg.sv
// types and constants shared by the socks5 reply parser modules
package sk5_pkg;

	localparam logic [2:0] PH_GREET = 3'd0;
	localparam logic [2:0] PH_AUTH  = 3'd1;
	localparam logic [2:0] PH_CONN  = 3'd2;
	localparam logic [2:0] PH_HLEN  = 3'd3;
	localparam logic [2:0] PH_ADDR  = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	localparam logic [3:0] ST_MORE        = 4'd0;
	localparam logic [3:0] ST_SEND_AUTH   = 4'd1;
	localparam logic [3:0] ST_SEND_CONN   = 4'd2;
	localparam logic [3:0] ST_AUTH_OK     = 4'd3;
	localparam logic [3:0] ST_OPEN        = 4'd4;
	localparam logic [3:0] ST_BAD_VER     = 4'd5;
	localparam logic [3:0] ST_REJECTED    = 4'd6;
	localparam logic [3:0] ST_BAD_METHOD  = 4'd7;
	localparam logic [3:0] ST_AUTH_FAIL   = 4'd8;
	localparam logic [3:0] ST_BAD_CONNVER = 4'd9;
	localparam logic [3:0] ST_CONN_FAIL   = 4'd10;
	localparam logic [3:0] ST_IGNORED     = 4'd11;

	localparam logic [7:0] SOCKS_VER    = 8'h05;
	localparam logic [7:0] METH_NONE    = 8'h00;
	localparam logic [7:0] METH_USERPW  = 8'h02;
	localparam logic [7:0] METH_REJECT  = 8'hFF;
	localparam logic [7:0] REP_OK       = 8'h00;
	localparam logic [7:0] ATYP_IPV4    = 8'h01;
	localparam logic [7:0] ATYP_HOST    = 8'h03;
	localparam logic [7:0] ATYP_IPV6    = 8'h04;

	localparam logic [8:0] LEFT_IPV4  = 9'd6;
	localparam logic [8:0] LEFT_IPV6  = 9'd18;
	localparam logic [8:0] LEFT_PORT  = 9'd2;

	typedef struct packed {
		logic       restart;
		logic [7:0] rx_byte;
	} sk5_in_t;

	typedef struct packed {
		logic [3:0] status;
		logic [7:0] reply_code;
		logic [7:0] bound_addr_type;
	} sk5_out_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [2:0] header_index;
		logic [8:0] bytes_left;
		logic [7:0] addr_type_hold;
	} sk5_state_t;

	localparam sk5_state_t STATE_RESET = '{
		phase: PH_GREET, header_index: 3'd0, bytes_left: 9'd0, addr_type_hold: 8'd0
	};

endpackage

FILE: src/sk5_parse.sv
// next-state and result logic for one received byte
module sk5_parse import sk5_pkg::*; (
	input  sk5_state_t state,
	input  sk5_in_t    item,
	output sk5_state_t state_next,
	output sk5_out_t   result
);

	sk5_state_t cur;
	logic [7:0] b;

	always_comb begin
		cur = item.restart ? STATE_RESET : state;
		b = item.rx_byte;
		state_next = cur;
		result = '{status: ST_MORE, reply_code: 8'd0, bound_addr_type: 8'd0};

		unique case (cur.phase)
			PH_GREET: begin
				if (cur.header_index == 3'd0) begin
					if (b != SOCKS_VER) begin
						result.status = ST_BAD_VER;
						state_next.phase = PH_DONE;
					end else begin
						state_next.header_index = 3'd1;
					end
				end else begin
					state_next.header_index = 3'd0;
					if (b == METH_NONE) begin
						result.status = ST_SEND_CONN;
						state_next.phase = PH_CONN;
					end else if (b == METH_USERPW) begin
						result.status = ST_SEND_AUTH;
						state_next.phase = PH_AUTH;
					end else if (b == METH_REJECT) begin
						result.status = ST_REJECTED;
						result.reply_code = b;
						state_next.phase = PH_DONE;
					end else begin
						result.status = ST_BAD_METHOD;
						result.reply_code = b;
						state_next.phase = PH_DONE;
					end
				end
			end
			PH_AUTH: begin
				// version byte of the auth reply is not checked
				if (cur.header_index == 3'd0) begin
					state_next.header_index = 3'd1;
				end else begin
					state_next.header_index = 3'd0;
					if (b == REP_OK) begin
						result.status = ST_AUTH_OK;
						state_next.phase = PH_CONN;
					end else begin
						result.status = ST_AUTH_FAIL;
						result.reply_code = b;
						state_next.phase = PH_DONE;
					end
				end
			end
			PH_CONN: begin
				if (cur.header_index == 3'd0) begin
					if (b != SOCKS_VER) begin
						result.status = ST_BAD_CONNVER;
						state_next.phase = PH_DONE;
					end else begin
						state_next.header_index = 3'd1;
					end
				end else if (cur.header_index == 3'd1) begin
					if (b != REP_OK) begin
						result.status = ST_CONN_FAIL;
						result.reply_code = b;
						state_next.phase = PH_DONE;
					end else begin
						state_next.header_index = 3'd2;
					end
				end else if (cur.header_index == 3'd2) begin
					// reserved byte
					state_next.header_index = 3'd3;
				end else begin
					state_next.header_index = 3'd0;
					state_next.addr_type_hold = b;
					if (b == ATYP_IPV4) begin
						state_next.bytes_left = LEFT_IPV4;
						state_next.phase = PH_ADDR;
					end else if (b == ATYP_IPV6) begin
						state_next.bytes_left = LEFT_IPV6;
						state_next.phase = PH_ADDR;
					end else if (b == ATYP_HOST) begin
						state_next.phase = PH_HLEN;
					end else begin
						// unknown type: only the port follows
						state_next.bytes_left = LEFT_PORT;
						state_next.phase = PH_ADDR;
					end
				end
			end
			PH_HLEN: begin
				state_next.bytes_left = {1'b0, b} + LEFT_PORT;
				state_next.phase = PH_ADDR;
			end
			PH_ADDR: begin
				if (cur.bytes_left <= 9'd1) begin
					state_next.bytes_left = 9'd0;
					state_next.phase = PH_DONE;
					result.status = ST_OPEN;
					result.bound_addr_type = cur.addr_type_hold;
				end else begin
					state_next.bytes_left = cur.bytes_left - 9'd1;
				end
			end
			default: begin
				// finished and unused phase codes
				result.status = ST_IGNORED;
			end
		endcase
	end

endmodule

FILE: src/socks5_client_reply_parser_top.sv
// socks5 client reply parser: input register, parse logic, result register
// a byte is taken into the input register, parsed, and its result is held in the result
// register until it is taken
// throughput: one byte per cycle while result_stall is low, one result per byte
// the input stage refills in the same cycle that the result register is taken
// reset clears the parser state to the greeting phase and empties both stages
module socks5_client_reply_parser_top import sk5_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  sk5_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output sk5_out_t result
);

	logic       valid_s1;
	sk5_in_t    item_s1;
	sk5_state_t state_q;
	sk5_state_t state_next;
	sk5_out_t   result_next;
	logic       valid_s2;
	sk5_out_t   result_s2;
	logic       s2_free;
	logic       s1_free;

	assign s2_free = !valid_s2 || !result_stall;
	assign s1_free = !valid_s1 || s2_free;
	assign item_stall = !s1_free;

	sk5_parse u_parse (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= STATE_RESET;
		end else begin
			if (s1_free) begin
				valid_s1 <= item_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && item_valid) begin
			item_s1 <= item;
		end
		if (s2_free && valid_s1) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

FILE: src/sk5_checker.sv
// port-level checks for the socks5 reply parser
module sk5_checker import sk5_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     item_valid,
	input logic     item_stall,
	input sk5_in_t  item,
	input logic     result_valid,
	input logic     result_stall,
	input sk5_out_t result
);

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status <= ST_IGNORED)
		else $error("status out of range");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.reply_code != 8'd0 |->
			result.status == ST_REJECTED || result.status == ST_BAD_METHOD ||
			result.status == ST_AUTH_FAIL || result.status == ST_CONN_FAIL)
		else $error("reply code with wrong status");

	a_atype: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bound_addr_type != 8'd0 |-> result.status == ST_OPEN)
		else $error("address type without open status");

	// an empty parser never stalls its input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled with free result stage");

endmodule

bind socks5_client_reply_parser_top sk5_checker u_sk5_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: tb/socks5_reply_checker.sv
// reply parser checker: predicts each result from accepted bytes and compares
`timescale 1ns / 1ps

module socks5_reply_checker import sk5_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  sk5_in_t     item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  sk5_out_t    result,
	output int unsigned outstanding,
	output int unsigned mismatches
);

	sk5_state_t parser;
	sk5_out_t   expected_replies[$];

	function automatic sk5_out_t parse_reply_byte(input sk5_in_t din);
		sk5_out_t   r;
		logic [7:0] b;
		r = '{status: ST_MORE, reply_code: 8'd0, bound_addr_type: 8'd0};
		b = din.rx_byte;
		if (din.restart)
			parser = STATE_RESET;
		case (parser.phase)
			PH_GREET: begin
				if (parser.header_index == 3'd0) begin
					if (b != SOCKS_VER) begin
						r.status = ST_BAD_VER;
						parser.phase = PH_DONE;
					end else
						parser.header_index = 3'd1;
				end else begin
					parser.header_index = 3'd0;
					if (b == METH_NONE) begin
						r.status = ST_SEND_CONN;
						parser.phase = PH_CONN;
					end else if (b == METH_USERPW) begin
						r.status = ST_SEND_AUTH;
						parser.phase = PH_AUTH;
					end else if (b == METH_REJECT) begin
						r.status = ST_REJECTED;
						r.reply_code = b;
						parser.phase = PH_DONE;
					end else begin
						r.status = ST_BAD_METHOD;
						r.reply_code = b;
						parser.phase = PH_DONE;
					end
				end
			end
			PH_AUTH: begin
				// auth version byte is taken without a check
				if (parser.header_index == 3'd0)
					parser.header_index = 3'd1;
				else begin
					parser.header_index = 3'd0;
					if (b == REP_OK) begin
						r.status = ST_AUTH_OK;
						parser.phase = PH_CONN;
					end else begin
						r.status = ST_AUTH_FAIL;
						r.reply_code = b;
						parser.phase = PH_DONE;
					end
				end
			end
			PH_CONN: begin
				if (parser.header_index == 3'd0) begin
					if (b != SOCKS_VER) begin
						r.status = ST_BAD_CONNVER;
						parser.phase = PH_DONE;
					end else
						parser.header_index = 3'd1;
				end else if (parser.header_index == 3'd1) begin
					if (b != REP_OK) begin
						r.status = ST_CONN_FAIL;
						r.reply_code = b;
						parser.phase = PH_DONE;
					end else
						parser.header_index = 3'd2;
				end else if (parser.header_index == 3'd2) begin
					parser.header_index = 3'd3;
				end else begin
					parser.header_index = 3'd0;
					parser.addr_type_hold = b;
					if (b == ATYP_IPV4) begin
						parser.bytes_left = LEFT_IPV4;
						parser.phase = PH_ADDR;
					end else if (b == ATYP_IPV6) begin
						parser.bytes_left = LEFT_IPV6;
						parser.phase = PH_ADDR;
					end else if (b == ATYP_HOST)
						parser.phase = PH_HLEN;
					else begin
						// unknown type: only the port follows
						parser.bytes_left = LEFT_PORT;
						parser.phase = PH_ADDR;
					end
				end
			end
			PH_HLEN: begin
				parser.bytes_left = 9'(b) + LEFT_PORT;
				parser.phase = PH_ADDR;
			end
			PH_ADDR: begin
				if (parser.bytes_left <= 9'd1) begin
					parser.bytes_left = 9'd0;
					r.status = ST_OPEN;
					r.bound_addr_type = parser.addr_type_hold;
					parser.phase = PH_DONE;
				end else
					parser.bytes_left = parser.bytes_left - 9'd1;
			end
			default: begin
				r.status = ST_IGNORED;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sk5_out_t want;
		if (!arst_n) begin
			parser = STATE_RESET;
			expected_replies.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			// results are popped first: a result never belongs to a byte taken at the same edge
			if (result_valid && !result_stall) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected result status %0d code %0h atype %0h", $time,
						result.status, result.reply_code, result.bound_addr_type);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want.status, result.status);
						mismatches++;
					end
					if (result.reply_code !== want.reply_code) begin
						$display("%0t: reply_code expected %0h got %0h", $time,
							want.reply_code, result.reply_code);
						mismatches++;
					end
					if (result.bound_addr_type !== want.bound_addr_type) begin
						$display("%0t: bound_addr_type expected %0h got %0h", $time,
							want.bound_addr_type, result.bound_addr_type);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall)
				expected_replies.push_back(parse_reply_byte(item));
			outstanding = expected_replies.size();
		end
	end

endmodule

FILE: tb/tb.sv
// testbench top: clock, reset, byte stimulus, result stalls, watchdog and verdict
`timescale 1ns / 1ps

module tb import sk5_pkg::*; ();

	localparam int unsigned RANDOM_ITEMS   = 1600;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	sk5_in_t     item;
	logic        result_valid;
	logic        result_stall;
	sk5_out_t    result;
	int unsigned outstanding;
	int unsigned mismatches;

	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          long_hold_req = 1'b0;

	socks5_client_reply_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	socks5_reply_checker u_reply_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.outstanding  (outstanding),
		.mismatches   (mismatches)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len(input bit quiet);
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic rst, input logic [7:0] b);
		int unsigned gap;
		@(negedge clk);
		gap = idle_len(tx_quiet);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= '{restart: rst, rx_byte: b};
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// one server reply stream: mostly well-formed, some noise, bad fields and cut-offs
	task automatic send_session();
		logic [7:0]  seq[$];
		logic [7:0]  meth;
		logic [7:0]  atyp;
		int unsigned r;
		int unsigned n;
		int unsigned alen;
		logic        first_rst;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			n = $urandom_range(1, 10);
			repeat (n) send_byte($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
			return;
		end
		seq.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : SOCKS_VER);
		r = $urandom_range(0, 99);
		if (r < 50)
			meth = METH_NONE;
		else if (r < 88)
			meth = METH_USERPW;
		else if (r < 94)
			meth = METH_REJECT;
		else
			meth = 8'($urandom_range(0, 255));
		seq.push_back(meth);
		if (meth == METH_USERPW) begin
			seq.push_back(8'($urandom_range(0, 255)));
			// auth success shares the zero code with the connect reply
			seq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : REP_OK);
		end
		seq.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : SOCKS_VER);
		seq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : REP_OK);
		seq.push_back(8'($urandom_range(0, 255)));
		r = $urandom_range(0, 99);
		if (r < 30)
			atyp = ATYP_IPV4;
		else if (r < 55)
			atyp = ATYP_IPV6;
		else if (r < 85)
			atyp = ATYP_HOST;
		else
			atyp = 8'($urandom_range(0, 255));
		seq.push_back(atyp);
		if (atyp == ATYP_IPV4)
			alen = 4;
		else if (atyp == ATYP_IPV6)
			alen = 16;
		else if (atyp == ATYP_HOST) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				alen = $urandom_range(200, 255);
			else if (r < 15)
				alen = 0;
			else
				alen = $urandom_range(1, 24);
			seq.push_back(8'(alen));
		end else
			alen = 0;
		repeat (alen + 2) seq.push_back(8'($urandom_range(0, 255)));
		// trailing bytes land after completion or an error
		repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, seq.size());
			while (seq.size() > n)
				void'(seq.pop_back());
		end
		first_rst = ($urandom_range(0, 19) != 0);
		foreach (seq[i])
			send_byte((i == 0) ? first_rst : ($urandom_range(0, 99) == 0), seq[i]);
	endtask

	// receiver side: random stall runs, plus one long hold on request
	initial begin
		int unsigned n;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				result_stall <= 1'b0;
			end else begin
				n = idle_len(rx_quiet);
				result_stall <= (n != 0);
				if (n > 1)
					repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int unsigned start_count;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bad greeting version straight out of reset, then an ignored byte
		send_byte(1'b0, 8'h00);
		send_byte(1'b0, 8'hFF);
		// no acceptable method
		send_byte(1'b1, SOCKS_VER);
		send_byte(1'b0, METH_REJECT);
		// unknown method
		send_byte(1'b1, SOCKS_VER);
		send_byte(1'b0, 8'h7F);
		// auth failure, auth version byte not checked
		send_byte(1'b1, SOCKS_VER);
		send_byte(1'b0, METH_USERPW);
		send_byte(1'b0, 8'hFF);
		send_byte(1'b0, 8'h80);
		// auth ok, then a bad connect version
		send_byte(1'b1, SOCKS_VER);
		send_byte(1'b0, METH_USERPW);
		send_byte(1'b0, 8'h00);
		send_byte(1'b0, REP_OK);
		send_byte(1'b0, 8'h04);
		// connect refused
		send_byte(1'b1, SOCKS_VER);
		send_byte(1'b0, METH_NONE);
		send_byte(1'b0, SOCKS_VER);
		send_byte(1'b0, 8'hFF);
		// hostname of length zero, unchecked reserved byte, then port
		send_byte(1'b1, SOCKS_VER);
		send_byte(1'b0, METH_NONE);
		send_byte(1'b0, SOCKS_VER);
		send_byte(1'b0, REP_OK);
		send_byte(1'b0, 8'hFF);
		send_byte(1'b0, ATYP_HOST);
		send_byte(1'b0, 8'h00);
		send_byte(1'b0, 8'hFF);
		send_byte(1'b0, 8'h00);
		wait_drained();

		// receiver holds off while the sender keeps pushing back to back
		long_hold_req = 1'b1;
		tx_quiet = 1'b1;
		start_count = bytes_sent;
		while (bytes_sent < start_count + 40)
			send_session();
		tx_quiet = 1'b0;
		wait_drained();

		start_count = bytes_sent;
		while (bytes_sent < start_count + RANDOM_ITEMS) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			send_session();
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: socks5_client_reply_parser_top.f
src/sk5_pkg.sv
src/sk5_parse.sv
src/socks5_client_reply_parser_top.sv
src/sk5_checker.sv
tb/socks5_reply_checker.sv
tb/tb.sv
